### hdl/mtf_zero_run_length_decoder_macros.svh
// Assertion macros shared by the run-length decoder checker.
`ifndef MTF_ZERO_RUN_LENGTH_DECODER_MACROS_SVH
`define MTF_ZERO_RUN_LENGTH_DECODER_MACROS_SVH

// Property checked only while reset is released.
`define MZRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, including during reset.
`define MZRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mzrl_pkg.sv
// Types and constants of the zero run-length decoder.
package mzrl_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned ExpW    = 4;
  localparam int unsigned MantHiW = 3;
  localparam int unsigned MantW   = MantHiW + CodeW;

  localparam int unsigned EscFlagBit = 7;

  typedef struct packed {
    logic [CodeW-1:0] code_byte;
    logic             end_of_stream;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0] run_value;
    logic [LenW-1:0]  run_length;
    logic             last_run;
    logic             truncated;
  } run_t;

  typedef struct packed {
    logic emit;
    run_t run;
  } dec_res_t;

endpackage

### hdl/mzrl_if.sv
// Valid/ready channel interfaces for code bytes and decoded runs.
interface mzrl_in_if;
  logic                          valid;
  logic                          ready;
  logic [mzrl_pkg::CodeW-1:0]    code_byte;
  logic                          end_of_stream;

  modport source (output valid, output code_byte, output end_of_stream, input ready);
  modport sink (input valid, input code_byte, input end_of_stream, output ready);
endinterface

interface mzrl_out_if;
  logic                          valid;
  logic                          ready;
  logic [mzrl_pkg::CodeW-1:0]    run_value;
  logic [mzrl_pkg::LenW-1:0]     run_length;
  logic                          last_run;
  logic                          truncated;

  modport source (output valid, output run_value, output run_length, output last_run,
                  output truncated, input ready);
  modport sink (input valid, input run_value, input run_length, input last_run,
                input truncated, output ready);
endinterface

### hdl/mtf_zero_run_length_decoder.sv
// Top level of the zero run-length decoder: input register, decoder and result register.
// A byte sits in the input register and its run, if any, in the result register.
// Takes one code byte per cycle unless the output stalls; decode sits between the registers.
// The input register frees itself whenever the result register is empty or being read.
// Synchronous active-low reset empties both registers and returns the decoder to
// expecting a header byte.
module mtf_zero_run_length_decoder (
  input  logic       clk,
  input  logic       rst_n,
  mzrl_in_if.sink    in_ch,
  mzrl_out_if.source out_ch
);

  mzrl_pkg::item_t    item_in;
  mzrl_pkg::item_t    item_q;
  mzrl_pkg::dec_res_t res;
  mzrl_pkg::run_t     run_q;
  logic               in_q_valid;
  logic               out_valid;
  logic               stall;
  logic               advance;
  logic               load;

  assign item_in.code_byte     = in_ch.code_byte;
  assign item_in.end_of_stream = in_ch.end_of_stream;

  assign stall       = out_valid & ~out_ch.ready;
  assign advance     = in_q_valid & ~stall;
  assign in_ch.ready = ~in_q_valid | ~stall;
  assign load        = in_ch.valid & in_ch.ready;

  mzrl_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .item_in (item_in),
    .advance (advance),
    .valid_o (in_q_valid),
    .item_o  (item_q)
  );

  mzrl_decoder u_decoder (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_q),
    .res   (res)
  );

  mzrl_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .res     (res),
    .ready   (out_ch.ready),
    .valid_o (out_valid),
    .run_o   (run_q)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.run_value  = run_q.run_value;
  assign out_ch.run_length = run_q.run_length;
  assign out_ch.last_run   = run_q.last_run;
  assign out_ch.truncated  = run_q.truncated;

endmodule

### hdl/mzrl_in_stage.sv
// Input register that holds one accepted code byte transaction.
module mzrl_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  mzrl_pkg::item_t item_in,
  input  logic            advance,
  output logic            valid_o,
  output mzrl_pkg::item_t item_o
);

  logic            valid_r;
  logic            valid_nxt;
  mzrl_pkg::item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

### hdl/mzrl_decoder.sv
// Token decoder: phase, escape and literal count state with the run computation.
module mzrl_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  mzrl_pkg::item_t    item,
  output mzrl_pkg::dec_res_t res
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_ESCAPE  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  phase_t                                       phase_r;
  phase_t                                       phase_nxt;
  logic [mzrl_pkg::CountW-1:0]                  esc_r;
  logic [mzrl_pkg::CountW-1:0]                  esc_nxt;
  logic [mzrl_pkg::CountW-1:0]                  lit_r;
  logic [mzrl_pkg::CountW-1:0]                  lit_nxt;
  logic [mzrl_pkg::ExpW-1:0]                    expo;
  logic [mzrl_pkg::MantW-1:0]                   mant;
  logic [mzrl_pkg::LenW-1:0]                    esc_len;
  logic                                         have_run;
  logic [mzrl_pkg::CodeW-1:0]                   value;
  logic [mzrl_pkg::LenW-1:0]                    length;
  logic [mzrl_pkg::CodeW-1:0]                   b;

  assign b       = item.code_byte;
  assign expo    = esc_r[mzrl_pkg::CountW-1 -: mzrl_pkg::ExpW];
  assign mant    = {esc_r[mzrl_pkg::MantHiW-1:0], b};
  assign esc_len = (mzrl_pkg::LenW'(1) << expo)
                 + mzrl_pkg::LenW'(mant) - mzrl_pkg::LenW'(1);

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    lit_nxt   = lit_r;
    have_run  = 1'b0;
    value     = '0;
    length    = '0;
    case (phase_r)
      PH_ESCAPE: begin
        phase_nxt = PH_HEADER;
        esc_nxt   = '0;
        length    = esc_len;
        have_run  = (esc_len != '0);
      end
      PH_LITERAL: begin
        have_run = 1'b1;
        value    = b;
        length   = mzrl_pkg::LenW'(1);
        lit_nxt  = lit_r - mzrl_pkg::CountW'(1);
        if (lit_nxt == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
        if (b[mzrl_pkg::EscFlagBit]) begin
          esc_nxt   = b[mzrl_pkg::CountW-1:0];
          phase_nxt = PH_ESCAPE;
        end else begin
          lit_nxt = b[mzrl_pkg::CountW-1:0];
          if (lit_nxt != '0) begin
            phase_nxt = PH_LITERAL;
          end
        end
      end
    endcase

    res.emit           = have_run | item.end_of_stream;
    res.run.run_value  = have_run ? value : '0;
    res.run.run_length = have_run ? length : '0;
    res.run.last_run   = item.end_of_stream;
    res.run.truncated  = item.end_of_stream & (phase_nxt != PH_HEADER);

    if (item.end_of_stream) begin
      phase_nxt = PH_HEADER;
      esc_nxt   = '0;
      lit_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      esc_r   <= '0;
      lit_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      lit_r   <= lit_nxt;
    end
  end

endmodule

### hdl/mzrl_out_stage.sv
// Result register that holds one run until the sink takes it.
module mzrl_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  mzrl_pkg::dec_res_t res,
  input  logic               ready,
  output logic               valid_o,
  output mzrl_pkg::run_t     run_o
);

  logic           valid_r;
  logic           valid_nxt;
  mzrl_pkg::run_t run_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = res.emit;
    end else if (ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      run_r <= res.run;
    end
  end

  assign valid_o = valid_r;
  assign run_o   = run_r;

endmodule

### hdl/mzrl_checker.sv
// Port-level checker for the zero run-length decoder and its bind statement.
`include "mtf_zero_run_length_decoder_macros.svh"

module mzrl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mzrl_pkg::CodeW-1:0]    run_value,
  input logic [mzrl_pkg::LenW-1:0]     run_length,
  input logic                          last_run,
  input logic                          truncated
);

  // A stalled result transaction keeps its payload.
  `MZRL_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(run_value) && $stable(run_length) && $stable(last_run) && $stable(truncated)), "result payload changed while stalled")

  // Only the final run of a stream may report truncation.
  `MZRL_ASSERT(a_trunc_last, (out_valid && !last_run) |-> !truncated, "truncated set on a run that is not last")

  // Runs that are not last are never empty.
  `MZRL_ASSERT(a_len_nonzero, (out_valid && !last_run) |-> (run_length != '0), "empty run that is not last")

  // Reset empties the result register.
  `MZRL_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind mtf_zero_run_length_decoder mzrl_checker u_mzrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .run_value  (out_ch.run_value),
  .run_length (out_ch.run_length),
  .last_run   (out_ch.last_run),
  .truncated  (out_ch.truncated)
);
